>>> rtl/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Types and constants shared by the timer table controller and datapath.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [2:0] MODE_REGISTER = 3'd0;
    localparam logic [2:0] MODE_DELAY    = 3'd1;
    localparam logic [2:0] MODE_SLEEP    = 3'd2;
    localparam logic [2:0] MODE_WAKEUP   = 3'd3;
    localparam logic [2:0] MODE_DELETE   = 3'd4;
    localparam logic [2:0] MODE_TICK     = 3'd5;
    localparam logic [2:0] MODE_DISPATCH = 3'd6;

    localparam logic [1:0] SLOT_FREE  = 2'd0;
    localparam logic [1:0] SLOT_READY = 2'd1;
    localparam logic [1:0] SLOT_WAIT  = 2'd2;
    localparam logic [1:0] SLOT_SLEEP = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ERROR = 2'd1;
    localparam logic [1:0] STATUS_NONE  = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot;
        logic [15:0] ticks;
        logic [15:0] period;
    } ttt_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_id;
        logic       last;
    } ttt_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request
        logic single;    // run a command that needs no walk
        logic walk_init; // clear walk index
        logic walk_step; // process one walk position
        logic rsp_take;  // output register consumed
    } ttt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_walk;   // request is tick, dispatch or delete of a busy slot
        logic walk_done; // walk index past end
        logic emit;      // current walk step produces a result
        logic rsp_full;  // output register holds a result
    } ttt_sts_t;

endpackage

>>> rtl/ttt_datapath.sv
// ----------------------------------------------------------------------------
// ttt_datapath
// Slot tables, order list and the per-slot walk used by tick, dispatch and
// delete.
// ----------------------------------------------------------------------------
module ttt_datapath import ttt_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  ttt_req_t req,
    input  ttt_cmd_t cmd,
    output ttt_sts_t sts,
    output ttt_rsp_t rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);

    logic [1:0]             mode_reg   [SLOTS];
    logic [COUNT_WIDTH-1:0] count_reg  [SLOTS];
    logic [COUNT_WIDTH-1:0] reload_reg [SLOTS];
    logic [IW-1:0]          order_reg  [SLOTS];
    logic [LW-1:0]          len_reg;

    ttt_req_t               req_reg;
    logic [LW-1:0]          idx_reg;   // read position
    logic [LW-1:0]          wr_reg;    // compaction write position
    logic                   any_reg;   // dispatch emitted something
    ttt_rsp_t               rsp_reg;
    logic                   full_reg;

    logic [COUNT_WIDTH-1:0] tk, per;
    logic                   slot_ok;
    logic [IW-1:0]          s;
    logic [IW-1:0]          free_idx;
    logic                   free_found;
    logic [IW-1:0]          t;
    logic [IW-1:0]          widx;
    logic                   pos_valid;
    logic                   is_ready_t;
    logic                   keep;
    logic [IW-1:0]          idx_i;
    logic                   single_ok;

    assign tk      = COUNT_WIDTH'(req_reg.ticks);
    assign per     = COUNT_WIDTH'(req_reg.period);
    assign slot_ok = 32'(req_reg.slot) < SLOTS;
    assign s       = IW'(req_reg.slot);
    assign idx_i   = IW'(idx_reg);
    assign widx    = IW'(wr_reg);

    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (mode_reg[i] == SLOT_FREE) begin
                free_idx   = IW'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb begin
        case (req_reg.mode)
            MODE_REGISTER: single_ok = free_found && len_reg < LW'(SLOTS);
            MODE_DELAY:    single_ok = slot_ok && mode_reg[s] != SLOT_FREE && tk != '0;
            MODE_SLEEP:    single_ok = slot_ok && mode_reg[s] != SLOT_FREE
                                       && mode_reg[s] != SLOT_SLEEP;
            MODE_WAKEUP:   single_ok = slot_ok && mode_reg[s] == SLOT_SLEEP;
            default:       single_ok = 1'b0;
        endcase
    end

    // tick walks slot index; dispatch and delete walk the order list
    assign pos_valid  = (req_reg.mode == MODE_TICK) ? (idx_reg < LW'(SLOTS))
                                                   : (idx_reg < len_reg);
    assign t          = order_reg[idx_i];
    assign is_ready_t = mode_reg[t] == SLOT_READY;
    always_comb begin
        keep = 1'b1;
        if (req_reg.mode == MODE_DISPATCH)
            keep = !(is_ready_t && reload_reg[t] == '0);
        else if (req_reg.mode == MODE_DELETE)
            keep = t != s;
    end

    assign sts.is_walk   = (req_reg.mode == MODE_TICK) || (req_reg.mode == MODE_DISPATCH)
                           || (req_reg.mode == MODE_DELETE && slot_ok
                               && mode_reg[s] != SLOT_FREE);
    assign sts.walk_done = !pos_valid;
    assign sts.emit      = !pos_valid
                           || (req_reg.mode == MODE_DISPATCH && is_ready_t);
    assign sts.rsp_full  = full_reg;
    assign rsp           = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                mode_reg[i]   <= SLOT_FREE;
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
            end
            len_reg  <= '0;
            full_reg <= 1'b0;
            idx_reg  <= '0;
            wr_reg   <= '0;
            any_reg  <= 1'b0;
        end else begin
            if (cmd.rsp_take)
                full_reg <= 1'b0;
            if (cmd.load)
                req_reg <= req;
            if (cmd.walk_init) begin
                idx_reg <= '0;
                wr_reg  <= '0;
                any_reg <= 1'b0;
            end
            if (cmd.single) begin
                full_reg        <= 1'b1;
                rsp_reg.status  <= single_ok ? STATUS_OK : STATUS_ERROR;
                rsp_reg.slot_id <= (req_reg.mode == MODE_REGISTER && single_ok)
                                   ? 4'(free_idx) : '0;
                rsp_reg.last    <= 1'b1;
                case (req_reg.mode)
                    MODE_REGISTER: begin
                        if (single_ok) begin
                            count_reg[free_idx]  <= tk;
                            reload_reg[free_idx] <= per;
                            mode_reg[free_idx]   <= (tk != '0) ? SLOT_WAIT : SLOT_READY;
                            order_reg[len_reg[IW-1:0]] <= free_idx;
                            len_reg              <= len_reg + 1'b1;
                        end
                    end
                    MODE_DELAY: begin
                        if (single_ok) begin
                            count_reg[s] <= tk;
                            mode_reg[s]  <= SLOT_WAIT;
                        end
                    end
                    MODE_SLEEP: begin
                        if (single_ok) begin
                            count_reg[s] <= '0;
                            mode_reg[s]  <= SLOT_SLEEP;
                        end
                    end
                    MODE_WAKEUP: begin
                        if (single_ok) begin
                            count_reg[s] <= '0;
                            mode_reg[s]  <= SLOT_READY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.walk_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (!pos_valid) begin
                    // end of walk; a held dispatch result becomes the last one
                    full_reg     <= 1'b1;
                    rsp_reg.last <= 1'b1;
                    if (!(req_reg.mode == MODE_DISPATCH && any_reg)) begin
                        rsp_reg.slot_id <= '0;
                        rsp_reg.status  <= (req_reg.mode == MODE_DISPATCH)
                                           ? STATUS_NONE : STATUS_OK;
                    end
                    if (req_reg.mode != MODE_TICK)
                        len_reg <= wr_reg;
                    if (req_reg.mode == MODE_DELETE) begin
                        mode_reg[s]   <= SLOT_FREE;
                        count_reg[s]  <= '0;
                        reload_reg[s] <= '0;
                    end
                end else if (req_reg.mode == MODE_TICK) begin
                    if (mode_reg[idx_i] == SLOT_WAIT) begin
                        if (count_reg[idx_i] != '0)
                            count_reg[idx_i] <= count_reg[idx_i] - 1'b1;
                        if (count_reg[idx_i] <= COUNT_WIDTH'(1))
                            mode_reg[idx_i] <= SLOT_READY;
                    end
                end else begin
                    if (keep) begin
                        order_reg[widx] <= t;
                        wr_reg          <= wr_reg + 1'b1;
                    end
                    if (req_reg.mode == MODE_DISPATCH && is_ready_t) begin
                        any_reg         <= 1'b1;
                        full_reg        <= 1'b1;
                        rsp_reg.status  <= STATUS_OK;
                        rsp_reg.slot_id <= 4'(t);
                        rsp_reg.last    <= 1'b0;
                        if (reload_reg[t] != '0) begin
                            count_reg[t] <= reload_reg[t];
                            mode_reg[t]  <= SLOT_WAIT;
                        end else begin
                            mode_reg[t]   <= SLOT_FREE;
                            count_reg[t]  <= '0;
                            reload_reg[t] <= '0;
                        end
                    end
                end
            end
        end
    end

endmodule

>>> rtl/ttt_ctrl.sv
// ----------------------------------------------------------------------------
// ttt_ctrl
// Request sequencer: accept, run one command or walk, hand results out.
// ----------------------------------------------------------------------------
module ttt_ctrl import ttt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  ttt_sts_t sts,
    output ttt_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       hold_reg, hold_next; // dispatch result pending before last mark

    // a dispatch result is released one step late so the final one gets last
    assign m_valid = sts.rsp_full && !(state_reg == ST_WALK && hold_reg);
    assign s_ready = state_reg == ST_IDLE && !sts.rsp_full;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        hold_next  = hold_reg;
        cmd.rsp_take = m_valid && m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.is_walk) begin
                    cmd.walk_init = 1'b1;
                    hold_next     = 1'b0;
                    state_next    = ST_WALK;
                end else begin
                    cmd.single = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                // step when a new result would not overwrite a held one
                if (!(sts.emit && sts.rsp_full && !hold_reg)
                    && !(sts.emit && hold_reg && !sts.walk_done)) begin
                    cmd.walk_step = 1'b1;
                    if (sts.walk_done) begin
                        hold_next  = 1'b0;
                        state_next = ST_DRAIN;
                    end else if (sts.emit) begin
                        hold_next = 1'b1;
                    end
                end else if (hold_reg && sts.emit && !sts.walk_done) begin
                    // release held result, next step after it drains
                    hold_next = 1'b0;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hold_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

>>> rtl/task_timer_table.sv
// ----------------------------------------------------------------------------
// task_timer_table
// Bank of timer slots with register, delay, sleep, wakeup, delete, tick and
// dispatch requests.
// ----------------------------------------------------------------------------
// Register, delay, sleep, wakeup and any rejected request pass through the
// request register and then the result register after acceptance. Tick walks
// every slot and dispatch and delete of a busy slot walk the order list, one
// position per cycle while no result waits for the consumer; each dispatched
// result holds the walk until the result before it is accepted. The datapath
// has a single walk position, so one walk runs at a time. The next request is
// taken in the cycle after the last result is accepted.
module task_timer_table import ttt_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ttt_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ttt_rsp_t m_data
);

    ttt_cmd_t cmd;
    ttt_sts_t sts;

    ttt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    ttt_datapath #(.SLOTS(SLOTS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .req(s_data), .cmd(cmd), .sts(sts),
        .rsp(m_data)
    );

endmodule

>>> rtl/ttt_checker.sv
// ----------------------------------------------------------------------------
// ttt_checker
// Port-level checks for the timer table.
// ----------------------------------------------------------------------------
module ttt_checker import ttt_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ttt_req_t s_data,
    input logic     m_valid,
    input logic     m_ready,
    input ttt_rsp_t m_data
);

    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= STATUS_NONE)
        else $error("bad status code");

    a_not_last_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.status == STATUS_OK)
        else $error("non-final result without ok status");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted back to back");

endmodule

bind task_timer_table ttt_checker u_ttt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives request sequences into the timer table and checks every response
// against a local model of the slot table, order list and counters.
// ----------------------------------------------------------------------------
module testbench;
    import ttt_pkg::*;

    localparam int NSLOT = 16;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ttt_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ttt_rsp_t m_data;

    task_timer_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    logic [1:0]  tbl_mode [NSLOT];
    logic [15:0] tbl_count [NSLOT];
    logic [15:0] tbl_reload [NSLOT];
    logic [3:0]  reg_order [$];

    ttt_req_t pending_reqs [$];
    ttt_rsp_t expected_rsps [$];
    int errors = 0;
    int n_rsp = 0;
    int n_dispatched = 0;
    bit calm = 1'b0;
    bit hold_send = 1'b0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic push_rsp(input logic [1:0] st, input logic [3:0] id, input logic lst);
        ttt_rsp_t r;
        r.status = st;
        r.slot_id = id;
        r.last = lst;
        expected_rsps.push_back(r);
    endtask

    task automatic predict_table(input ttt_req_t q);
        int i;
        int n;
        logic [3:0] t;
        logic [3:0] kept [$];
        case (q.mode)
            MODE_REGISTER: begin
                for (i = 0; i < NSLOT; i++) if (tbl_mode[i] == SLOT_FREE) break;
                if (i >= NSLOT) begin
                    push_rsp(STATUS_ERROR, 0, 1);
                end else begin
                    tbl_count[i] = q.ticks;
                    tbl_reload[i] = q.period;
                    tbl_mode[i] = (q.ticks != 0) ? SLOT_WAIT : SLOT_READY;
                    reg_order.push_back(i[3:0]);
                    push_rsp(STATUS_OK, i[3:0], 1);
                end
            end
            MODE_DELAY: begin
                if (tbl_mode[q.slot] == SLOT_FREE || q.ticks == 0) begin
                    push_rsp(STATUS_ERROR, 0, 1);
                end else begin
                    tbl_count[q.slot] = q.ticks;
                    tbl_mode[q.slot] = SLOT_WAIT;
                    push_rsp(STATUS_OK, 0, 1);
                end
            end
            MODE_SLEEP: begin
                if (tbl_mode[q.slot] == SLOT_FREE || tbl_mode[q.slot] == SLOT_SLEEP) begin
                    push_rsp(STATUS_ERROR, 0, 1);
                end else begin
                    tbl_count[q.slot] = 0;
                    tbl_mode[q.slot] = SLOT_SLEEP;
                    push_rsp(STATUS_OK, 0, 1);
                end
            end
            MODE_WAKEUP: begin
                if (tbl_mode[q.slot] != SLOT_SLEEP) begin
                    push_rsp(STATUS_ERROR, 0, 1);
                end else begin
                    tbl_count[q.slot] = 0;
                    tbl_mode[q.slot] = SLOT_READY;
                    push_rsp(STATUS_OK, 0, 1);
                end
            end
            MODE_DELETE: begin
                if (tbl_mode[q.slot] == SLOT_FREE) begin
                    push_rsp(STATUS_ERROR, 0, 1);
                end else begin
                    foreach (reg_order[k]) if (reg_order[k] != q.slot) kept.push_back(reg_order[k]);
                    reg_order = kept;
                    tbl_mode[q.slot] = SLOT_FREE;
                    tbl_count[q.slot] = 0;
                    tbl_reload[q.slot] = 0;
                    push_rsp(STATUS_OK, 0, 1);
                end
            end
            MODE_TICK: begin
                for (i = 0; i < NSLOT; i++) begin
                    if (tbl_mode[i] == SLOT_WAIT) begin
                        if (tbl_count[i] != 0) tbl_count[i] = tbl_count[i] - 1'b1;
                        if (tbl_count[i] == 0) tbl_mode[i] = SLOT_READY;
                    end
                end
                push_rsp(STATUS_OK, 0, 1);
            end
            MODE_DISPATCH: begin
                n = 0;
                foreach (reg_order[k]) begin
                    t = reg_order[k];
                    if (tbl_mode[t] == SLOT_READY) begin
                        push_rsp(STATUS_OK, t, 0);
                        n++;
                        if (tbl_reload[t] != 0) begin
                            tbl_count[t] = tbl_reload[t];
                            tbl_mode[t] = SLOT_WAIT;
                            kept.push_back(t);
                        end else begin
                            tbl_mode[t] = SLOT_FREE;
                            tbl_count[t] = 0;
                            tbl_reload[t] = 0;
                        end
                    end else begin
                        kept.push_back(t);
                    end
                end
                reg_order = kept;
                n_dispatched += n;
                if (n == 0) push_rsp(STATUS_NONE, 0, 1);
                else expected_rsps[expected_rsps.size() - 1].last = 1'b1;
            end
            default: push_rsp(STATUS_ERROR, 0, 1);
        endcase
    endtask

    function automatic ttt_req_t mk(input logic [2:0] md, input logic [3:0] sl,
                                    input logic [15:0] tk, input logic [15:0] pr);
        ttt_req_t q;
        q.mode = md;
        q.slot = sl;
        q.ticks = tk;
        q.period = pr;
        return q;
    endfunction

    function automatic logic [3:0] busy_slot();
        int k;
        if (reg_order.size() == 0 || $urandom_range(0, 5) == 0) return $urandom_range(0, 15);
        k = $urandom_range(0, reg_order.size() - 1);
        return reg_order[k];
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_reqs.size() != 0 && !hold_send
                    && (calm || $urandom_range(0, 99) >= 27)) begin
                s_data <= pending_reqs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on acceptance, check responses
    always @(posedge aclk) begin
        ttt_rsp_t e;
        if (aresetn) begin
            if (s_valid && s_ready) predict_table(s_data);
            if (m_valid && m_ready) begin
                n_rsp++;
                if (expected_rsps.size() == 0) begin
                    report($sformatf("unexpected response %p", m_data));
                end else begin
                    e = expected_rsps.pop_front();
                    if (m_data.status !== e.status)
                        report($sformatf("status %0d, want %0d", m_data.status, e.status));
                    if (m_data.slot_id !== e.slot_id)
                        report($sformatf("slot_id %0d, want %0d", m_data.slot_id, e.slot_id));
                    if (m_data.last !== e.last)
                        report($sformatf("last %0d, want %0d", m_data.last, e.last));
                end
            end
        end
        m_ready <= calm || ($urandom_range(0, 99) >= 27);
    end

    task automatic drain();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int i;
        int r;
        for (i = 0; i < NSLOT; i++) begin
            tbl_mode[i] = SLOT_FREE;
            tbl_count[i] = 0;
            tbl_reload[i] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        pending_reqs.push_back(mk(MODE_DISPATCH, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_REGISTER, 4'hf, 16'h0000, 16'h0000));
        pending_reqs.push_back(mk(MODE_REGISTER, 0, 16'hffff, 16'hffff));
        pending_reqs.push_back(mk(MODE_REGISTER, 0, 16'h0001, 16'h0002));
        pending_reqs.push_back(mk(MODE_DISPATCH, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_TICK, 4'hf, 16'hffff, 16'hffff));
        pending_reqs.push_back(mk(MODE_DELAY, 1, 16'h0000, 0));
        pending_reqs.push_back(mk(MODE_DELAY, 9, 16'h0005, 0));
        pending_reqs.push_back(mk(MODE_DELAY, 1, 16'h0003, 0));
        pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_WAKEUP, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_WAKEUP, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_WAKEUP, 7, 0, 0));
        pending_reqs.push_back(mk(MODE_DELETE, 7, 0, 0));
        pending_reqs.push_back(mk(MODE_DISPATCH, 0, 0, 0));
        pending_reqs.push_back(mk(MODE_DELETE, 1, 0, 0));
        pending_reqs.push_back(mk(3'd7, 4'hf, 16'hffff, 16'hffff));
        for (i = 0; i < 17; i++) pending_reqs.push_back(mk(MODE_REGISTER, 0, 0, i[15:0] & 1));
        pending_reqs.push_back(mk(MODE_DISPATCH, 0, 0, 0));
        drain();

        // queue one more dispatch and send it with steady valid and ready
        hold_send = 1'b1;
        calm = 1'b1;
        pending_reqs.push_back(mk(MODE_DISPATCH, 0, 0, 0));
        @(posedge aclk);
        hold_send = 1'b0;
        drain();

        for (i = 0; i < 200; i++) begin
            calm = (i >= 60 && i < 100);
            r = $urandom_range(0, 99);
            if (r < 18)
                pending_reqs.push_back(mk(MODE_REGISTER, $urandom, $urandom_range(0, 4),
                    ($urandom_range(0, 2) == 0) ? 16'h0 : $urandom_range(1, 4)));
            else if (r < 21)
                pending_reqs.push_back(mk(MODE_REGISTER, $urandom, $urandom, $urandom));
            else if (r < 48)
                pending_reqs.push_back(mk(MODE_TICK, $urandom, $urandom, $urandom));
            else if (r < 68)
                pending_reqs.push_back(mk(MODE_DISPATCH, $urandom, $urandom, $urandom));
            else if (r < 75)
                pending_reqs.push_back(mk(MODE_DELAY, busy_slot(),
                    ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 3), $urandom));
            else if (r < 82)
                pending_reqs.push_back(mk(MODE_SLEEP, busy_slot(), $urandom, $urandom));
            else if (r < 89)
                pending_reqs.push_back(mk(MODE_WAKEUP, busy_slot(), $urandom, $urandom));
            else if (r < 97)
                pending_reqs.push_back(mk(MODE_DELETE, busy_slot(), $urandom, $urandom));
            else
                pending_reqs.push_back(mk(3'd7, $urandom, $urandom, $urandom));
            // keep the predictor's view of busy slots roughly current
            if ((i % 8) == 7) drain();
        end
        drain();
        calm = 1'b0;
        repeat (40) @(posedge aclk);

        $display("checked %0d responses, %0d timer dispatches", n_rsp, n_dispatched);
        $display("covered register, delay, sleep, wakeup, delete, tick, dispatch and bad mode");
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/ttt_pkg.sv
rtl/ttt_datapath.sv
rtl/ttt_ctrl.sv
rtl/task_timer_table.sv
rtl/ttt_checker.sv
sim/testbench.sv
